/* hw/rtl/sdi_pkg.sv */
`default_nettype none

package sdi_pkg;

  // Default table geometry
  localparam int unsigned DEF_AXES   = 4;
  localparam int unsigned DEF_POINTS = 4;

  // Fixed field widths
  localparam int unsigned SPEED_W = 16;
  localparam int unsigned DUTY_W  = 7;

  // Divider: |num| < 2^DIVW, quotient never exceeds 127 so QW bits suffice
  localparam int unsigned DIVW  = 24;
  localparam int unsigned QW    = 8;
  localparam int unsigned DCNTW = $clog2(QW + 1);

  // Constant duties
  localparam logic [DUTY_W-1:0] INVALID_DUTY   = 7'd50;
  localparam logic [7:0]        WRITE_DUTY_MIN = 8'd30;
  localparam logic [7:0]        WRITE_DUTY_MAX = 8'd95;
  localparam logic [DUTY_W-1:0] RST_BASE_DUTY  = 7'd50;
  localparam logic [DUTY_W-1:0] RST_MAX_DUTY   = 7'd75;

  typedef enum logic [1:0] {
    MODE_LOOKUP = 2'd0,
    MODE_WRITE  = 2'd1,
    MODE_ENABLE = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    STAT_LOOKUP  = 2'd0,
    STAT_WRITE   = 2'd1,
    STAT_IGNORED = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    REG_BASE_DUTY = 2'd0,
    REG_MAX_DUTY  = 2'd1
  } reg_e;

  typedef struct packed {
    logic [SPEED_W-1:0] speed;
    logic [DUTY_W-1:0]  duty;
  } pt_t;

  typedef struct packed {
    logic               start;
    logic [DIVW-1:0]    dividend;
    logic [SPEED_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic          done;
    logic [QW-1:0] quotient;
  } div_rsp_t;

  localparam logic [SPEED_W-1:0] DFLT_SPEED [4] = '{16'd0, 16'd800, 16'd3000, 16'd8000};
  localparam logic [DUTY_W-1:0]  DFLT_DUTY  [4] = '{7'd50, 7'd55, 7'd65, 7'd75};

  function automatic pt_t default_point(input logic [1:0] idx);
    pt_t p;
    p.speed = DFLT_SPEED[idx];
    p.duty  = DFLT_DUTY[idx];
    return p;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/sdi_table.sv */
`default_nettype none

module sdi_table import sdi_pkg::*; #(
  parameter int unsigned Axes   = DEF_AXES,
  parameter int unsigned Points = DEF_POINTS,
  localparam int unsigned Depth = Axes * Points,
  localparam int unsigned AW    = (Depth > 1) ? $clog2(Depth) : 1,
  localparam int unsigned PW    = $clog2(Points)
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] addr_i,
  input  wire logic [PW-1:0] pidx_i,
  input  wire pt_t           wdata_i,
  output pt_t                rdata_o
);

  pt_t             mem_q [Depth];
  pt_t             rd_q;
  logic [Depth-1:0] vld_q;
  logic            rd_vld_q;
  logic [PW-1:0]   rd_pidx_q;

  // Single port, registered read
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rd_q <= mem_q[addr_i];
      end
    end
  end

  // Entries never written read back as their reset point
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      rd_vld_q  <= 1'b0;
      rd_pidx_q <= '0;
    end else if (en_i) begin
      if (we_i) begin
        vld_q[addr_i] <= 1'b1;
      end else begin
        rd_vld_q  <= vld_q[addr_i];
        rd_pidx_q <= pidx_i;
      end
    end
  end

  assign rdata_o = rd_vld_q ? rd_q : default_point(2'(rd_pidx_q));

endmodule

`default_nettype wire

/* hw/rtl/sdi_div.sv */
`default_nettype none

module sdi_div import sdi_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output div_rsp_t      rsp_o
);

  logic                run_q;
  logic [DCNTW-1:0]    cnt_q;
  logic [SPEED_W-1:0]  rem_q;
  logic [QW-1:0]       quo_q;
  logic [SPEED_W-1:0]  den_q;
  logic [SPEED_W:0]    trial;
  logic                ge;

  // Quotient fits QW bits, so the upper dividend bits start below the divisor
  assign trial = {rem_q, quo_q[QW-1]};
  assign ge    = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else if (req_i.start) begin
      run_q <= 1'b1;
      cnt_q <= DCNTW'(QW);
    end else if (run_q) begin
      if (cnt_q == '0) begin
        run_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= req_i.dividend[DIVW-1:QW];
      quo_q <= req_i.dividend[QW-1:0];
      den_q <= req_i.divisor;
    end else if (run_q && cnt_q != '0) begin
      rem_q <= ge ? SPEED_W'(trial - {1'b0, den_q}) : trial[SPEED_W-1:0];
      quo_q <= {quo_q[QW-2:0], ge};
    end
  end

  assign rsp_o.done     = run_q && (cnt_q == '0);
  assign rsp_o.quotient = quo_q;

endmodule

`default_nettype wire

/* hw/rtl/speed_to_duty_interpolator_core.sv */
`default_nettype none

// Channel   Direction  Transfer condition       Payload
// item      in         start && !busy           mode_i axis_i speed_i point_index_i
//                                               duty_in_i enable_in_i
// result    out        done_o (one cycle)       duty_out_o status_o
// config    in         cfg_valid_i&&cfg_ready_o cfg_index_i cfg_data_i
//
// One item at a time; busy stays high from the accepting edge through the done_o cycle.
// Writes, enable changes, ignored items and lookups on an invalid or disabled axis go
// from idle straight to the done_o state. A lookup walks the axis's points through the
// single table port, one point per cycle, and, when it must interpolate, then runs the
// 8-step shift-subtract divider.
// Reset is asynchronous, active low; the table needs no clearing pass, per-entry
// valid bits make unwritten entries read as the default points.
// The result receiver cannot stall; config writes are always ready.

module speed_to_duty_interpolator_core import sdi_pkg::*; #(
  parameter int unsigned Axes   = DEF_AXES,
  parameter int unsigned Points = DEF_POINTS
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // item channel
  input  wire logic         start,
  output logic              busy,
  input  wire logic [1:0]   mode_i,
  input  wire logic [2:0]   axis_i,
  input  wire logic [15:0]  speed_i,
  input  wire logic [1:0]   point_index_i,
  input  wire logic [7:0]   duty_in_i,
  input  wire logic         enable_in_i,
  // result channel
  output logic              done_o,
  output logic [6:0]        duty_out_o,
  output logic [1:0]        status_o,
  // config channel
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic [1:0]   cfg_index_i,
  input  wire logic [6:0]   cfg_data_i
);

  localparam int unsigned Depth = Axes * Points;
  localparam int unsigned AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned PW    = $clog2(Points);
  localparam int unsigned AXW   = (Axes > 1) ? $clog2(Axes) : 1;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_SCAN  = 7'b0000010,
    ST_MUL   = 7'b0000100,
    ST_DSTRT = 7'b0001000,
    ST_DIV   = 7'b0010000,
    ST_DONE  = 7'b0100000,
    ST_SPARE = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // config registers
  logic [DUTY_W-1:0] base_q, max_q;

  // per-axis enables
  logic [Axes-1:0] en_q;

  // item context
  logic [SPEED_W-1:0] spd_q;
  logic [AXW-1:0]     axis_q;
  logic [PW-1:0]      cnt_q, cnt_d;
  pt_t                prev_q, prev_d;
  logic [SPEED_W-1:0] dx_q, dx_d;
  logic [SPEED_W-1:0] den_q, den_d;
  logic signed [7:0]  dd_q, dd_d;
  logic [DUTY_W-1:0]  d0_q, d0_d;
  logic signed [24:0] prod_q;
  logic [DUTY_W-1:0]  duty_q, duty_d;
  status_e            stat_q, stat_d;

  // table port
  logic          tb_en, tb_we;
  logic [AW-1:0] tb_addr;
  logic [PW-1:0] tb_pidx;
  pt_t           tb_wdata, tb_rdata;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic          accept;
  logic [2:0]    axis_m1;
  logic [AXW-1:0] axis_in;
  logic          axis_ok;
  logic          pidx_ok;
  logic [AW-1:0] in_base, q_base;
  logic [7:0]    din_clamped;
  logic [24:0]   prod_mag;
  logic signed [9:0] interp, upper;

  assign busy        = (state_q != ST_IDLE);
  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;

  assign axis_m1 = axis_i - 3'd1;
  assign axis_in = AXW'(axis_m1);
  assign axis_ok = (axis_i != 3'd0) && (32'(axis_i) <= Axes);
  assign pidx_ok = 32'(point_index_i) < Points;
  assign in_base = AW'(32'(axis_in) * Points);
  assign q_base  = AW'(32'(axis_q) * Points);

  // Clamp a written duty into the legal PWM window
  always_comb begin
    din_clamped = duty_in_i;
    if (din_clamped < WRITE_DUTY_MIN) din_clamped = WRITE_DUTY_MIN;
    if (din_clamped > WRITE_DUTY_MAX) din_clamped = WRITE_DUTY_MAX;
  end

  // Signed interpolation: quotient truncates toward zero, then clamp max first, base last
  assign prod_mag = prod_q[24] ? 25'(-prod_q) : 25'(prod_q);
  assign interp   = $signed({3'b000, d0_q}) +
                    (prod_q[24] ? -$signed({2'b00, div_rsp.quotient})
                                :  $signed({2'b00, div_rsp.quotient}));
  assign upper    = (interp > $signed({3'b000, max_q})) ? $signed({3'b000, max_q}) : interp;

  assign div_req.start    = (state_q == ST_DSTRT);
  assign div_req.dividend = prod_mag[DIVW-1:0];
  assign div_req.divisor  = den_q;

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    prev_d   = prev_q;
    dx_d     = dx_q;
    den_d    = den_q;
    dd_d     = dd_q;
    d0_d     = d0_q;
    duty_d   = duty_q;
    stat_d   = stat_q;
    tb_en    = 1'b0;
    tb_we    = 1'b0;
    tb_addr  = in_base + AW'(point_index_i);
    tb_pidx  = PW'(point_index_i);
    tb_wdata = '{speed: speed_i, duty: din_clamped[DUTY_W-1:0]};

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_DONE;
          duty_d  = '0;
          stat_d  = STAT_IGNORED;
          cnt_d   = '0;
          case (mode_i)
            MODE_LOOKUP: begin
              stat_d = STAT_LOOKUP;
              if (!axis_ok || !en_q[axis_in]) begin
                duty_d = INVALID_DUTY;
              end else begin
                // fetch the first point of the axis
                tb_en   = 1'b1;
                tb_addr = in_base;
                tb_pidx = '0;
                state_d = ST_SCAN;
              end
            end
            MODE_WRITE: begin
              if (axis_ok && pidx_ok) begin
                tb_en  = 1'b1;
                tb_we  = 1'b1;
                stat_d = STAT_WRITE;
              end
            end
            MODE_ENABLE: begin
              if (axis_ok) stat_d = STAT_WRITE;
            end
            default: begin
              stat_d = STAT_IGNORED;
            end
          endcase
        end
      end

      ST_SCAN: begin
        // tb_rdata holds point cnt_q, prev_q holds point cnt_q-1
        if (cnt_q == '0) begin
          if (spd_q <= tb_rdata.speed) begin
            duty_d  = base_q;
            state_d = ST_DONE;
          end else begin
            prev_d  = tb_rdata;
            cnt_d   = cnt_q + 1'b1;
            tb_en   = 1'b1;
            tb_addr = q_base + AW'(cnt_q + 1'b1);
            tb_pidx = cnt_q + 1'b1;
          end
        end else if (spd_q >= prev_q.speed && spd_q <= tb_rdata.speed) begin
          if (tb_rdata.speed == prev_q.speed) begin
            duty_d  = prev_q.duty;
            state_d = ST_DONE;
          end else begin
            dx_d    = spd_q - prev_q.speed;
            den_d   = tb_rdata.speed - prev_q.speed;
            dd_d    = $signed({1'b0, tb_rdata.duty}) - $signed({1'b0, prev_q.duty});
            d0_d    = prev_q.duty;
            state_d = ST_MUL;
          end
        end else if (cnt_q == PW'(Points - 1)) begin
          // past every segment: hold the last point's duty
          duty_d  = tb_rdata.duty;
          state_d = ST_DONE;
        end else begin
          prev_d  = tb_rdata;
          cnt_d   = cnt_q + 1'b1;
          tb_en   = 1'b1;
          tb_addr = q_base + AW'(cnt_q + 1'b1);
          tb_pidx = cnt_q + 1'b1;
        end
      end

      ST_MUL: begin
        state_d = ST_DSTRT;
      end

      ST_DSTRT: begin
        state_d = ST_DIV;
      end

      ST_DIV: begin
        if (div_rsp.done) begin
          duty_d  = (upper < $signed({3'b000, base_q})) ? base_q : upper[DUTY_W-1:0];
          state_d = ST_DONE;
        end
      end

      ST_DONE: begin
        state_d = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      base_q  <= RST_BASE_DUTY;
      max_q   <= RST_MAX_DUTY;
      en_q    <= '1;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_BASE_DUTY: base_q <= cfg_data_i;
          REG_MAX_DUTY:  max_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (accept && mode_i == MODE_ENABLE && axis_ok) begin
        en_q[axis_in] <= enable_in_i;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      spd_q  <= speed_i;
      axis_q <= axis_in;
    end
    cnt_q  <= cnt_d;
    prev_q <= prev_d;
    dx_q   <= dx_d;
    den_q  <= den_d;
    dd_q   <= dd_d;
    d0_q   <= d0_d;
    duty_q <= duty_d;
    stat_q <= stat_d;
    if (state_q == ST_MUL) begin
      prod_q <= $signed({1'b0, dx_q}) * dd_q;
    end
  end

  assign done_o     = (state_q == ST_DONE);
  assign duty_out_o = duty_q;
  assign status_o   = stat_q;

  sdi_table #(
    .Axes   (Axes),
    .Points (Points)
  ) u_table (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (tb_en),
    .we_i    (tb_we),
    .addr_i  (tb_addr),
    .pidx_i  (tb_pidx),
    .wdata_i (tb_wdata),
    .rdata_o (tb_rdata)
  );

  sdi_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy) else $error("accepted item did not raise busy");

  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o && !busy) else $error("result strobe repeated");

  a_write_zero_duty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o != STAT_LOOKUP |-> duty_out_o == '0)
    else $error("non-lookup result carries a duty");

  a_div_in_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> state_q == ST_DIV) else $error("divider finished outside its wait");

  a_table_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tb_en && tb_we |-> accept && mode_i == MODE_WRITE)
    else $error("table written outside a point write");
`endif

endmodule

`default_nettype wire

/* tb/sv/speed_to_duty_interpolator_core_tb.sv */
module speed_to_duty_interpolator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sdi_pkg::*;

  localparam int NUM_AXES = 4;
  localparam int NUM_PTS  = 4;

  // Codes outside the package enums: spare mode and unmapped register slots
  localparam logic [1:0] MODE_SPARE   = 2'd3;
  localparam logic [1:0] REG_UNUSED_A = 2'd2;
  localparam logic [1:0] REG_UNUSED_B = 2'd3;

  // Idle cycles after the last result before touching the register port
  localparam int SETTLE_CYCLES = 4;
  // Drain limit at the end of the run, in cycles
  localparam int DRAIN_LIMIT   = 5000;

  typedef struct packed {
    logic [6:0] duty;
    logic [1:0] status;
  } duty_result_t;

  // DUT ports; every input is known from time zero
  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        start         = 1'b0;
  logic        busy;
  logic [1:0]  mode_i        = '0;
  logic [2:0]  axis_i        = '0;
  logic [15:0] speed_i       = '0;
  logic [1:0]  point_index_i = '0;
  logic [7:0]  duty_in_i     = '0;
  logic        enable_in_i   = 1'b0;
  logic        done_o;
  logic [6:0]  duty_out_o;
  logic [1:0]  status_o;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i   = '0;
  logic [6:0]  cfg_data_i    = '0;

  // Shadow copy of the block's table, enables and clamp registers
  logic [15:0] pt_speed [NUM_AXES][NUM_PTS];
  logic [6:0]  pt_duty  [NUM_AXES][NUM_PTS];
  logic        ax_en    [NUM_AXES];
  logic [6:0]  clamp_lo;
  logic [6:0]  clamp_hi;

  duty_result_t duty_due_q[$];
  int           mismatch_count  = 0;
  int           sender_idle_pct = 0;

  speed_to_duty_interpolator_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .mode_i        (mode_i),
    .axis_i        (axis_i),
    .speed_i       (speed_i),
    .point_index_i (point_index_i),
    .duty_in_i     (duty_in_i),
    .enable_in_i   (enable_in_i),
    .done_o        (done_o),
    .duty_out_o    (duty_out_o),
    .status_o      (status_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs on a handshake
  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Duty prediction
  // ---------------------------------------------------------------------------

  // Load the power-on table: default curve on every axis, all axes on
  function automatic void load_default_table();
    for (int a = 0; a < NUM_AXES; a++) begin
      ax_en[a] = 1'b1;
      for (int p = 0; p < NUM_PTS; p++) begin
        pt_speed[a][p] = DFLT_SPEED[p];
        pt_duty[a][p]  = DFLT_DUTY[p];
      end
    end
    clamp_lo = RST_BASE_DUTY;
    clamp_hi = RST_MAX_DUTY;
  endfunction

  // Piecewise-linear lookup on one axis. The first segment whose ends bound
  // the speed wins; falling segments interpolate downward with the quotient
  // truncated toward zero. Clamp to max first, then to base, so base wins
  // when the two registers cross.
  function automatic logic [6:0] interp_duty(int ax, int spd);
    int s0, s1, d0, d1, d;
    if (spd <= int'(pt_speed[ax][0])) return clamp_lo;
    for (int i = 0; i < NUM_PTS - 1; i++) begin
      s0 = pt_speed[ax][i];
      s1 = pt_speed[ax][i+1];
      if (spd >= s0 && spd <= s1) begin
        d0 = pt_duty[ax][i];
        d1 = pt_duty[ax][i+1];
        if (s1 == s0) return d0[6:0];
        d = d0 + ((spd - s0) * (d1 - d0)) / (s1 - s0);
        if (d > int'(clamp_hi)) d = clamp_hi;
        if (d < int'(clamp_lo)) d = clamp_lo;
        return d[6:0];
      end
    end
    return pt_duty[ax][NUM_PTS-1];
  endfunction

  // Advance the shadow state by one accepted item and return its result
  function automatic duty_result_t duty_table_step(logic [1:0] mode, logic [2:0] axis,
                                                   logic [15:0] spd, logic [1:0] pidx,
                                                   logic [7:0] din, logic en);
    duty_result_t r;
    logic         axis_ok;
    logic [7:0]   dclamp;
    axis_ok  = (axis >= 1) && (axis <= NUM_AXES);
    r.duty   = '0;
    r.status = STAT_IGNORED;
    dclamp   = din;
    if (dclamp < WRITE_DUTY_MIN) dclamp = WRITE_DUTY_MIN;
    if (dclamp > WRITE_DUTY_MAX) dclamp = WRITE_DUTY_MAX;
    case (mode)
      MODE_LOOKUP: begin
        r.status = STAT_LOOKUP;
        if (!axis_ok || !ax_en[axis-1]) r.duty = INVALID_DUTY;
        else r.duty = interp_duty(axis - 1, spd);
      end
      MODE_WRITE: begin
        if (axis_ok && pidx < NUM_PTS) begin
          pt_speed[axis-1][pidx] = spd;
          pt_duty[axis-1][pidx]  = dclamp[6:0];
          r.status = STAT_WRITE;
        end
      end
      MODE_ENABLE: begin
        if (axis_ok) begin
          ax_en[axis-1] = en;
          r.status = STAT_WRITE;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: check results, track register writes, predict accepted items
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] mismatch %s: got %0d want %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk_i) begin
    duty_result_t want;
    if (rst_ni) begin
      // A result is on the ports for one cycle only; check it at the edge that ends it
      if (done_o) begin
        if (duty_due_q.size() == 0) begin
          report_mismatch("result with nothing pending, duty", duty_out_o, 0);
        end else begin
          want = duty_due_q.pop_front();
          if (duty_out_o !== want.duty) report_mismatch("duty_out", duty_out_o, want.duty);
          if (status_o !== want.status) report_mismatch("status", status_o, want.status);
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_BASE_DUTY: clamp_lo = cfg_data_i;
          REG_MAX_DUTY:  clamp_hi = cfg_data_i;
          default: ;
        endcase
      end
      if (start && !busy) begin
        duty_due_q.push_back(duty_table_step(mode_i, axis_i, speed_i, point_index_i,
                                             duty_in_i, enable_in_i));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Drop start and hold until every pending result has come back
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk_i);
    while (duty_due_q.size() != 0) @(posedge clk_i);
  endtask

  // Send one item. start stays high after the transfer so that a following
  // item with no gap goes out back to back; any pause lowers it first.
  task automatic send_item(logic [1:0] mode, logic [2:0] axis, logic [15:0] spd,
                           logic [1:0] pidx, logic [7:0] din, logic en);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < sender_idle_pct) gap++;
    if (sender_idle_pct != 0 && $urandom_range(99) < 2) begin
      wait_drained();
    end else if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start         <= 1'b1;
    mode_i        <= mode;
    axis_i        <= axis;
    speed_i       <= spd;
    point_index_i <= pidx;
    duty_in_i     <= din;
    enable_in_i   <= en;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // Write one clamp register; only while the block is idle
  task automatic set_register(logic [1:0] idx, logic [6:0] value);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Lookup with random filler on the fields the lookup ignores
  task automatic send_lookup(logic [2:0] axis, logic [15:0] spd);
    send_item(MODE_LOOKUP, axis, spd, 2'($urandom_range(3)), 8'($urandom_range(255)),
              1'($urandom_range(1)));
  endtask

  task automatic send_point(logic [2:0] axis, logic [1:0] pidx, logic [15:0] spd,
                            logic [7:0] din);
    send_item(MODE_WRITE, axis, spd, pidx, din, 1'($urandom_range(1)));
  endtask

  task automatic send_enable(logic [2:0] axis, logic en);
    send_item(MODE_ENABLE, axis, 16'($urandom_range(65535)), 2'($urandom_range(3)),
              8'($urandom_range(255)), en);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Walk the default curve: base at the first point, interior segments, the end
  // of the last segment and beyond it, and axes outside the valid range
  task automatic test_default_curve();
    send_lookup(3'd1, 16'd0);
    send_lookup(3'd1, 16'd400);
    send_lookup(3'd1, 16'd800);
    send_lookup(3'd1, 16'd5500);
    send_lookup(3'd1, 16'd8000);
    send_lookup(3'd1, 16'd65535);
    send_lookup(3'd0, 16'd1000);
    send_lookup(3'd7, 16'd1000);
  endtask

  // Point writes: duty clamped at both ends, top speed, rejected axis, spare mode
  task automatic test_point_writes();
    send_point(3'd4, 2'd3, 16'd65535, 8'd255);
    send_point(3'd4, 2'd0, 16'd0, 8'd0);
    send_lookup(3'd4, 16'd65535);
    send_point(3'd0, 2'd1, 16'd1234, 8'd60);
    send_item(MODE_SPARE, 3'd2, 16'd4321, 2'd2, 8'd70, 1'b1);
  endtask

  // Falling segment: truncation toward zero, and a drop below base
  task automatic test_falling_segment();
    send_point(3'd3, 2'd1, 16'd1000, 8'd95);
    send_point(3'd3, 2'd2, 16'd3000, 8'd30);
    send_lookup(3'd3, 16'd2000);
    send_lookup(3'd3, 16'd2900);
  endtask

  // Disabled axis reads the fixed duty; enable on a bad axis is rejected
  task automatic test_axis_enable();
    send_enable(3'd2, 1'b0);
    send_lookup(3'd2, 16'd2000);
    send_enable(3'd5, 1'b1);
    send_enable(3'd2, 1'b1);
    send_lookup(3'd2, 16'd2000);
  endtask

  // Random mix; lookups favor speeds near the current table points so the
  // segment search and the divider see boundaries, not just open ranges
  task automatic test_random_traffic(int n_items, int idle_pct);
    int          r, ax, k, spd;
    logic [2:0]  axis;
    sender_idle_pct = idle_pct;
    for (int n = 0; n < n_items; n++) begin
      r = $urandom_range(99);
      if ($urandom_range(9) == 0) begin
        k    = $urandom_range(3);
        axis = (k == 0) ? 3'd0 : 3'(k + 4);
      end else begin
        axis = 3'($urandom_range(1, NUM_AXES));
      end
      ax = (axis >= 1 && axis <= NUM_AXES) ? axis - 1 : 0;
      k  = $urandom_range(NUM_PTS - 1);
      if (r < 50) begin
        if ($urandom_range(2) == 0) begin
          spd = $urandom_range(65535);
        end else begin
          spd = int'(pt_speed[ax][k]) + $urandom_range(40) - 20;
          if (spd < 0) spd = 0;
          if (spd > 65535) spd = 65535;
        end
        send_lookup(axis, 16'(spd));
      end else if (r < 80) begin
        case ($urandom_range(4))
          0:       spd = $urandom_range(65535);
          1:       spd = pt_speed[ax][k ^ 1];
          default: spd = k * 3000 + $urandom_range(2999);
        endcase
        send_point(axis, 2'(k), 16'(spd), 8'($urandom_range(255)));
      end else if (r < 92) begin
        send_enable(axis, 1'($urandom_range(3) != 0));
      end else if (r < 96) begin
        send_item(MODE_SPARE, axis, 16'($urandom_range(65535)), 2'($urandom_range(3)),
                  8'($urandom_range(255)), 1'($urandom_range(1)));
      end else begin
        send_lookup(axis, ($urandom_range(1) != 0) ? 16'hFFFF : 16'h0000);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    int waited;
    load_default_table();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    sender_idle_pct = 0;
    test_default_curve();
    test_point_writes();
    test_falling_segment();
    test_axis_enable();

    // Phases: back to back, sparse sender, back to back again (the receiver
    // cannot stall), light idling, sparse again; clamp registers move between phases
    test_random_traffic(300, 0);
    set_register(REG_BASE_DUTY, 7'd0);
    set_register(REG_MAX_DUTY, 7'd100);
    set_register(REG_UNUSED_A, 7'($urandom_range(127)));
    test_random_traffic(300, 76);
    set_register(REG_BASE_DUTY, 7'd100);
    set_register(REG_MAX_DUTY, 7'd0);
    set_register(REG_UNUSED_B, 7'($urandom_range(127)));
    test_random_traffic(150, 0);
    set_register(REG_BASE_DUTY, 7'($urandom_range(30, 60)));
    set_register(REG_MAX_DUTY, 7'($urandom_range(60, 100)));
    test_random_traffic(300, 9);
    set_register(REG_BASE_DUTY, RST_BASE_DUTY);
    set_register(REG_MAX_DUTY, RST_MAX_DUTY);
    test_random_traffic(150, 76);

    // Drain with a limit, then keep the clock running so the block can show strays
    start  <= 1'b0;
    waited = 0;
    @(posedge clk_i);
    while (duty_due_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (40) @(posedge clk_i);
    if (duty_due_q.size() != 0) report_mismatch("results never returned", 0, duty_due_q.size());

    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
